[rtl/thermistor_adc_to_temperature_macros.svh]
// assertion macros for the thermistor converter
// used by the top level only, no other dependencies
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_MACROS_SVH

// same-cycle implication, disabled in reset
`define TADC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tadc assertion failed");

// next-cycle implication, disabled in reset
`define TADC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tadc assertion failed");

`endif

[rtl/tadc_pkg.sv]
// shared types and constants for the thermistor converter
// no dependencies
package tadc_pkg;

  // status codes of a result word
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OPEN = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // sideband that travels with each word through the pipeline
  typedef struct packed {
    logic valid;
    logic open;
    logic neg;
    logic sat;
  } tag_t;

  localparam int LOG_W  = 36;   // log2 in Q32 with 4 integer bits
  localparam int BETA_W = 13;
  localparam int Q1_W   = 51;   // ln magnitude shifted to Q47
  localparam int D_W    = 53;   // denominator in Q47
  localparam int Q2_W   = 80;   // 2^79 dividend width
  localparam int CQ_W   = 54;   // celsius in Q32, signed
  localparam int SC_W   = 60;   // scaled tenths in Q32, signed
  localparam int RND_W  = 28;   // rounded tenths, signed

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] INV_FULL = ((64'd100 << 47) + 64'd14907) / 64'd29815;
  localparam logic [63:0] K_FULL = ((64'd27315 << 32) + 64'd50) / 64'd100;
  localparam logic [63:0] SAT_LIMIT = 64'd1 << 29;
  localparam logic [63:0] F_OFFSET = 64'd320 << 32;

  localparam logic signed [15:0] C_MIN = -16'sd2732;
  localparam logic signed [15:0] C_MAX = 16'sd20000;
  localparam logic signed [16:0] F_MIN = -17'sd4597;
  localparam logic signed [16:0] F_MAX = 17'sd36320;
  localparam logic [BETA_W-1:0] BETA_RESET = 13'd4250;

endpackage

[rtl/tadc_log2.sv]
// two-lane pipelined log2 in Q32, one fraction bit per stage by squaring
// depends on tadc_pkg
module tadc_log2 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [15:0]    n_a,
  input  logic [15:0]    n_b,
  input  tadc_pkg::tag_t tag_in,
  output logic [35:0]    l_a,
  output logic [35:0]    l_b,
  output tadc_pkg::tag_t tag_out
);
  import tadc_pkg::*;

  localparam int STEPS = 32;

  logic [31:0] x_r    [2][STEPS+1];
  logic [31:0] frac_r [2][STEPS+1];
  logic [3:0]  k_r    [2][STEPS+1];
  tag_t        tag_r  [STEPS+1];
  logic [15:0] n_in   [2];

  assign n_in[0] = n_a;
  assign n_in[1] = n_b;

  genvar lane, s;
  generate
    for (lane = 0; lane < 2; lane++) begin : g_lane
      // normalize: find leading one, mantissa to Q31
      logic [15:0] n_fix;
      logic [3:0]  k_nxt;
      logic [31:0] x_nxt;
      always_comb begin
        n_fix = (n_in[lane] == 16'd0) ? 16'd1 : n_in[lane];
        k_nxt = 4'd0;
        for (int b = 0; b < 16; b++) begin
          if (n_fix[b]) k_nxt = 4'(b);
        end
        x_nxt = {16'd0, n_fix} << (5'd31 - {1'b0, k_nxt});
      end
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[lane][0]    <= x_nxt;
          k_r[lane][0]    <= k_nxt;
          frac_r[lane][0] <= 32'd0;
        end
      end

      // squaring steps
      for (s = 1; s <= STEPS; s++) begin : g_step
        logic [63:0] sq;
        logic [32:0] t;
        logic [31:0] xs_nxt;
        logic [31:0] fr_nxt;
        always_comb begin
          sq = 64'(x_r[lane][s-1]) * 64'(x_r[lane][s-1]);
          t  = sq[63:31];
          xs_nxt = t[32] ? t[32:1] : t[31:0];
          fr_nxt = {frac_r[lane][s-1][30:0], t[32]};
        end
        always_ff @(posedge clk) begin
          if (en) begin
            x_r[lane][s]    <= xs_nxt;
            frac_r[lane][s] <= fr_nxt;
            k_r[lane][s]    <= k_r[lane][s-1];
          end
        end
      end
    end

    // sideband line
    for (s = 0; s <= STEPS; s++) begin : g_tag
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[s] <= '0;
        end else if (en) begin
          tag_r[s] <= (s == 0) ? tag_in : tag_r[(s == 0) ? 0 : s - 1];
        end
      end
    end
  endgenerate

  assign l_a     = {k_r[0][STEPS], frac_r[0][STEPS]};
  assign l_b     = {k_r[1][STEPS], frac_r[1][STEPS]};
  assign tag_out = tag_r[STEPS];

endmodule

[rtl/tadc_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on tadc_pkg
module tadc_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  tadc_pkg::tag_t   tag_in,
  output logic [NUM_W-1:0] quo,
  output tadc_pkg::tag_t   tag_out
);
  import tadc_pkg::*;

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  tag_t             tag_r [NUM_W];

  logic [DEN_W-1:0] rem_in [NUM_W];
  logic [NUM_W-1:0] quo_in [NUM_W];
  logic [NUM_W-1:0] num_in [NUM_W];
  logic [DEN_W-1:0] den_in [NUM_W];
  tag_t             tag_st [NUM_W];

  genvar i;
  generate
    for (i = 0; i < NUM_W; i++) begin : g_stage
      // stage inputs
      if (i == 0) begin : g_first
        assign rem_in[i] = '0;
        assign quo_in[i] = '0;
        assign num_in[i] = num;
        assign den_in[i] = den;
        assign tag_st[i] = tag_in;
      end else begin : g_next
        assign rem_in[i] = rem_r[i-1];
        assign quo_in[i] = quo_r[i-1];
        assign num_in[i] = num_r[i-1];
        assign den_in[i] = den_r[i-1];
        assign tag_st[i] = tag_r[i-1];
      end

      // trial subtract
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_nxt;
      logic [NUM_W-1:0] quo_nxt;
      always_comb begin
        trial   = {rem_in[i], num_in[i][NUM_W-1-i]};
        diff    = trial - {1'b0, den_in[i]};
        ge      = (trial >= {1'b0, den_in[i]});
        rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_nxt = quo_in[i];
        quo_nxt[NUM_W-1-i] = ge;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          quo_r[i] <= quo_nxt;
          num_r[i] <= num_in[i];
          den_r[i] <= den_in[i];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[i] <= '0;
        end else if (en) begin
          tag_r[i] <= tag_st[i];
        end
      end
    end
  endgenerate

  assign quo     = quo_r[NUM_W-1];
  assign tag_out = tag_r[NUM_W-1];

endmodule

[rtl/thermistor_adc_to_temperature.sv]
// thermistor reading to tenths of Celsius and Fahrenheit by the beta equation
// word path: log2, stages a and b, beta divide, stage c, kelvin divide, stages e, f and g
// throughput: one word per cycle; the whole pipeline stalls only while a result waits
// reset: synchronous active-low rst_n clears all valid bits, beta returns to 4250
// depends on tadc_pkg, tadc_log2, tadc_div and the macros header
`include "thermistor_adc_to_temperature_macros.svh"

module thermistor_adc_to_temperature #(
  parameter int ADC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_adc_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_celsius_tenths,
  output logic signed [16:0]  out_fahrenheit_tenths,
  output logic [1:0]          out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [12:0]         cfg_beta_constant
);
  import tadc_pkg::*;

  localparam logic [16:0] FULL_SCALE = 17'd1 << ADC_BITS;

  logic en;
  logic [BETA_W-1:0] beta_r;
  logic out_valid_r;
  logic signed [15:0] out_c_r;
  logic signed [16:0] out_f_r;
  status_t out_st_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // beta register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= BETA_RESET;
    end else if (cfg_valid) begin
      beta_r <= cfg_beta_constant;
    end
  end

  // entry: mask reading, form both log arguments
  logic [15:0] v16;
  logic [16:0] fs_minus;
  tag_t tag_e;
  always_comb begin
    v16      = 16'(in_adc_sample[ADC_BITS-1:0]);
    fs_minus = FULL_SCALE - {1'b0, v16};
    tag_e       = '0;
    tag_e.valid = in_valid;
    tag_e.open  = (v16 == 16'd0);
  end

  logic [LOG_W-1:0] lp, lv;
  tag_t tag_l;
  tadc_log2 u_log2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .n_a(fs_minus[15:0]), .n_b(v16), .tag_in(tag_e),
    .l_a(lp), .l_b(lv), .tag_out(tag_l)
  );

  // stage a: log2 ratio magnitude and sign
  logic [LOG_W-1:0] mag_r;
  tag_t tag_a_nxt;
  tag_t tag_a_r;
  always_comb begin
    tag_a_nxt     = tag_l;
    tag_a_nxt.neg = (lv > lp);
  end
  always_ff @(posedge clk) begin
    if (en) mag_r <= (lv > lp) ? (lv - lp) : (lp - lv);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
    end else if (en) begin
      tag_a_r <= tag_a_nxt;
    end
  end

  // stage b: scale by ln 2
  logic [63:0] lo_prod;
  logic [35:0] hi_prod;
  logic [LOG_W-1:0] lnmag_r;
  tag_t tag_b_r;
  always_comb begin
    hi_prod = 36'(mag_r[35:32]) * 36'(LN2_Q32);
    lo_prod = 64'(mag_r[31:0]) * 64'(LN2_Q32);
  end
  always_ff @(posedge clk) begin
    if (en) lnmag_r <= hi_prod + 36'(lo_prod[63:32]);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r <= '0;
    end else if (en) begin
      tag_b_r <= tag_a_r;
    end
  end

  // ln ratio over beta, Q47
  logic [BETA_W-1:0] beta_eff;
  logic [Q1_W-1:0] q1;
  tag_t tag_q1;
  assign beta_eff = (beta_r == '0) ? BETA_W'(1) : beta_r;
  tadc_div #(.NUM_W(Q1_W), .DEN_W(BETA_W)) u_div_beta (
    .clk(clk), .rst_n(rst_n), .en(en),
    .num({lnmag_r, 15'd0}), .den(beta_eff), .tag_in(tag_b_r),
    .quo(q1), .tag_out(tag_q1)
  );

  // stage c: denominator and tiny-denominator check
  logic signed [D_W:0] d_full;
  logic [D_W-1:0] d_r;
  tag_t tag_c_nxt;
  tag_t tag_c_r;
  always_comb begin
    if (tag_q1.neg) d_full = $signed((D_W+1)'(INV_FULL)) - $signed((D_W+1)'(q1));
    else            d_full = $signed((D_W+1)'(INV_FULL)) + $signed((D_W+1)'(q1));
    tag_c_nxt     = tag_q1;
    tag_c_nxt.sat = (d_full < $signed((D_W+1)'(SAT_LIMIT)));
  end
  always_ff @(posedge clk) begin
    if (en) d_r <= d_full[D_W-1:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_c_r <= '0;
    end else if (en) begin
      tag_c_r <= tag_c_nxt;
    end
  end

  // kelvin in Q32 as 2^79 over the denominator
  logic [Q2_W-1:0] kq;
  tag_t tag_k;
  tadc_div #(.NUM_W(Q2_W), .DEN_W(D_W)) u_div_kelvin (
    .clk(clk), .rst_n(rst_n), .en(en),
    .num(Q2_W'(1) << (Q2_W - 1)), .den(d_r), .tag_in(tag_c_r),
    .quo(kq), .tag_out(tag_k)
  );

  // stage e: celsius and fahrenheit scaling in Q32
  logic signed [CQ_W-1:0] cq;
  logic signed [SC_W-1:0] c_s_r, f_s_r;
  tag_t tag_e_r;
  assign cq = $signed({2'b00, kq[CQ_W-3:0]}) - $signed(CQ_W'(K_FULL));
  always_ff @(posedge clk) begin
    if (en) begin
      c_s_r <= SC_W'(cq) * SC_W'(10);
      f_s_r <= SC_W'(cq) * SC_W'(18) + $signed(SC_W'(F_OFFSET));
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_e_r <= '0;
    end else if (en) begin
      tag_e_r <= tag_k;
    end
  end

  // round Q32 to integer, halves away from zero
  function automatic logic signed [RND_W-1:0] round_q32(input logic signed [SC_W-1:0] x);
    logic [SC_W-1:0] m;
    logic [RND_W-1:0] r;
    begin
      if (!x[SC_W-1]) m = SC_W'(x) + (SC_W'(1) << 31);
      else            m = (SC_W'(0) - SC_W'(x)) + (SC_W'(1) << 31);
      r = m[RND_W+31:32];
      round_q32 = x[SC_W-1] ? $signed(RND_W'(0) - r) : $signed(r);
    end
  endfunction

  // stage f: rounding
  logic signed [RND_W-1:0] c_rnd_r, f_rnd_r;
  tag_t tag_f_r;
  always_ff @(posedge clk) begin
    if (en) begin
      c_rnd_r <= round_q32(c_s_r);
      f_rnd_r <= round_q32(f_s_r);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_f_r <= '0;
    end else if (en) begin
      tag_f_r <= tag_e_r;
    end
  end

  // stage g: special cases and clamping into the output register
  logic signed [15:0] c_nxt;
  logic signed [16:0] f_nxt;
  status_t st_nxt;
  always_comb begin
    c_nxt  = c_rnd_r[15:0];
    f_nxt  = f_rnd_r[16:0];
    st_nxt = ST_OK;
    if (c_rnd_r > RND_W'(C_MAX)) begin
      c_nxt = C_MAX; st_nxt = ST_SAT;
    end
    if (c_rnd_r < RND_W'(C_MIN)) begin
      c_nxt = C_MIN; st_nxt = ST_SAT;
    end
    if (f_rnd_r > RND_W'(F_MAX)) begin
      f_nxt = F_MAX; st_nxt = ST_SAT;
    end
    if (f_rnd_r < RND_W'(F_MIN)) begin
      f_nxt = F_MIN; st_nxt = ST_SAT;
    end
    if (tag_f_r.sat) begin
      c_nxt = C_MAX; f_nxt = F_MAX; st_nxt = ST_SAT;
    end
    if (tag_f_r.open) begin
      c_nxt = C_MIN; f_nxt = F_MIN; st_nxt = ST_OPEN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c_r  <= c_nxt;
      out_f_r  <= f_nxt;
      out_st_r <= st_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_f_r.valid;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_celsius_tenths    = out_c_r;
  assign out_fahrenheit_tenths = out_f_r;
  assign out_status            = out_st_r;

  // checks on result words
  `TADC_ASSERT_NOW(a_open_value, clk, rst_n, out_valid && out_status == ST_OPEN, out_celsius_tenths == C_MIN && out_fahrenheit_tenths == F_MIN)
  `TADC_ASSERT_NOW(a_ok_in_range, clk, rst_n, out_valid && out_status == ST_OK, out_celsius_tenths >= C_MIN && out_celsius_tenths <= C_MAX)
  `TADC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_status == ST_OK || out_status == ST_OPEN || out_status == ST_SAT)
  `TADC_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))

endmodule

[dv/tb.sv]
// testbench for the thermistor reading to temperature converter
// predicts each result word with a fixed-point beta-equation model and checks it
// depends on tadc_pkg and the thermistor_adc_to_temperature top level
`timescale 1ns / 1ps

module tb;
  import tadc_pkg::*;

  typedef struct {
    logic signed [15:0] c10;
    logic signed [16:0] f10;
    status_t st;
  } temp_word_t;

  // expected result words in arrival order
  class temp_scoreboard;
    temp_word_t pending[$];
    int errs;
    logic [12:0] beta;

    function new();
      errs = 0;
      beta = BETA_RESET;
    endfunction

    // log2 in Q32 by repeated squaring
    function automatic logic [63:0] log2_fix(logic [63:0] n);
      int k;
      logic [63:0] x, frac;
      k = 0;
      frac = 0;
      n = n & 64'hFFFF;
      if (n == 0) n = 1;
      while (k < 15 && (n >> (k + 1)) != 0) k++;
      x = n << (31 - k);
      for (int i = 0; i < 32; i++) begin
        x = (x * x) >> 31;
        frac = frac << 1;
        if (x >= (64'd1 << 32)) begin
          x = x >> 1;
          frac[0] = 1'b1;
        end
      end
      return (64'(k) << 32) | frac;
    endfunction

    function automatic longint round_fix(longint x);
      logic [63:0] m;
      if (x >= 0) begin
        m = (64'(x) + (64'd1 << 31)) >> 32;
        return longint'(m);
      end
      m = (64'd0 - 64'(x) + (64'd1 << 31)) >> 32;
      return -longint'(m);
    endfunction

    // note an accepted reading and queue its expected word
    function void note_reading(logic [15:0] v);
      temp_word_t w;
      logic [63:0] lp, lnv, mag, lnmag, q, r, b;
      logic neg;
      longint d, cq, c10, f10;
      w.st = ST_OK;
      b = (beta != 0) ? 64'(beta) : 64'd1;
      if (v == 0) begin
        w.c10 = C_MIN; w.f10 = F_MIN; w.st = ST_OPEN;
        pending.push_back(w);
        return;
      end
      lp = log2_fix(64'd65536 - 64'(v));
      lnv = log2_fix(64'(v));
      neg = lnv > lp;
      mag = neg ? lnv - lp : lp - lnv;
      lnmag = (mag >> 32) * 64'(LN2_Q32) + (((mag & 64'hFFFFFFFF) * 64'(LN2_Q32)) >> 32);
      q = (lnmag << 15) / b;
      d = neg ? longint'(INV_FULL) - longint'(q) : longint'(INV_FULL) + longint'(q);
      if (d < (longint'(1) << 29)) begin
        w.c10 = C_MAX; w.f10 = F_MAX; w.st = ST_SAT;
        pending.push_back(w);
        return;
      end
      // kelvin = 2^79 / d by long division
      r = 1;
      q = 0;
      for (int i = 0; i < 79; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= 64'(d)) begin
          r = r - 64'(d);
          q[0] = 1'b1;
        end
      end
      cq = longint'(q) - longint'(K_FULL);
      c10 = round_fix(cq * 10);
      f10 = round_fix(cq * 18 + longint'(F_OFFSET));
      if (c10 > C_MAX) begin c10 = C_MAX; w.st = ST_SAT; end
      if (c10 < C_MIN) begin c10 = C_MIN; w.st = ST_SAT; end
      if (f10 > F_MAX) begin f10 = F_MAX; w.st = ST_SAT; end
      if (f10 < F_MIN) begin f10 = F_MIN; w.st = ST_SAT; end
      w.c10 = c10[15:0];
      w.f10 = f10[16:0];
      pending.push_back(w);
    endfunction

    // compare a result word with the oldest expectation
    function void check_word(logic signed [15:0] c, logic signed [16:0] f, logic [1:0] s);
      temp_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected result word c=%0d f=%0d st=%0d", c, f, s);
        errs++;
        return;
      end
      w = pending.pop_front();
      if (c !== w.c10) begin
        $error("celsius_tenths expected %0d actual %0d", w.c10, c); errs++;
      end
      if (f !== w.f10) begin
        $error("fahrenheit_tenths expected %0d actual %0d", w.f10, f); errs++;
      end
      if (s !== w.st) begin
        $error("status expected %0d actual %0d", w.st, s); errs++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_adc_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_celsius_tenths;
  logic signed [16:0] out_fahrenheit_tenths;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_beta_constant = '0;

  temp_scoreboard sb = new();
  longint cycles = 0;
  logic stall_mode = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  thermistor_adc_to_temperature u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_adc_sample(in_adc_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_celsius_tenths(out_celsius_tenths),
    .out_fahrenheit_tenths(out_fahrenheit_tenths), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_beta_constant(cfg_beta_constant)
  );

  // result side: check words and stall on a shifting pattern
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_word(out_celsius_tenths, out_fahrenheit_tenths, out_status);
      if ((cycles % 400) == 0) stall_mode <= ~stall_mode;
      out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
    if (cycles > 1500000) begin
      $display("tb: errors");
      $finish;
    end
  end

  // send one reading word
  task automatic send_reading(logic [15:0] v);
    in_valid <= 1'b1;
    in_adc_sample <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_reading(v);
  endtask

  // random gap with the valid line low
  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait for every expected word, plus pipeline drain
  task automatic drain();
    idle_gap(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_beta(logic [12:0] b);
    cfg_valid <= 1'b1;
    cfg_beta_constant <= b;
    do @(posedge clk); while (!cfg_ready);
    sb.beta = b;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int left;
    logic [15:0] v;
    left = n;
    while (left > 0) begin
      for (int k = $urandom_range(1, 30); k > 0 && left > 0; k--) begin
        case ($urandom_range(0, 9))
          0: v = 16'($urandom_range(0, 15));
          1: v = 16'($urandom_range(65520, 65535));
          default: v = 16'($urandom_range(0, 65535));
        endcase
        send_reading(v);
        left--;
      end
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [15:0] directed[$];
    logic [12:0] betas[$];
    directed = '{16'd0, 16'd1, 16'd2, 16'd100, 16'd1000, 16'd16384, 16'd32767,
                 16'd32768, 16'd32769, 16'd49152, 16'd60000, 16'd65000,
                 16'd65534, 16'd65535, 16'h5555, 16'hAAAA, 16'd8192, 16'd4096};
    betas = '{13'd3500, 13'd5000, 13'd0, 13'd1, 13'd8191, 13'd4000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed words at reset beta
    foreach (directed[i]) send_reading(directed[i]);
    drain();
    random_phase(600);
    drain();
    // remaining phases sweep beta including its extremes
    foreach (betas[j]) begin
      write_beta(betas[j]);
      foreach (directed[i]) if (i < 6) send_reading(directed[i]);
      random_phase(j < 4 ? 180 : 120);
      drain();
    end
    if (sb.errs == 0 && sb.pending.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end
endmodule
